// ===== src/gbcg_pkg.sv =====
// Shared types, constants and register codes for the grid band coordinate generator.
package gbcg_pkg;

	// Largest grid dimension; oversize dimension registers are clamped to it
	localparam int unsigned MAX_DIM = 4096;
	localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);
	localparam int unsigned COORD_W = 13;
	localparam int unsigned TOTAL_W = 25;
	localparam int unsigned CFG_W   = 13;
	localparam int unsigned NREG    = 4;

	// cycles for the geometry pipe to settle after reset or a register write
	localparam logic [2:0] SETTLE_CYCLES = 3'd4;

	typedef enum logic [2:0] {
		REG_WALK_MODE   = 3'd0,
		REG_GRID_COLS   = 3'd1,
		REG_GRID_ROWS   = 3'd2,
		REG_BORDER      = 3'd3,
		REG_STENCIL     = 3'd4,
		REG_FREE_SURF   = 3'd5,
		REG_BAND_ROW    = 3'd6
	} reg_idx_t;

	localparam logic [2:0] MODE_FRAME = 3'd1;
	localparam logic [2:0] MODE_BAND  = 3'd2;
	localparam logic [2:0] MODE_GRID  = 3'd4;

	// signed grid position, wide enough for degenerate geometry
	typedef logic signed [14:0] gpos_t;
	typedef logic [DIM_W-1:0]   dim_t;
	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [TOTAL_W-1:0] total_t;

	typedef struct packed {
		coord_t coord_x;
		coord_t coord_y;
		logic   last;
		logic   error;
		total_t total;
	} rsp_t;

endpackage

// ===== src/gbcg_if.sv =====
// Valid/ready channel interfaces for request and result words.
interface gbcg_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

interface gbcg_rsp_if;
	logic                  valid;
	logic                  ready;
	gbcg_pkg::coord_t      coord_x;
	gbcg_pkg::coord_t      coord_y;
	logic                  last;
	logic                  error;
	gbcg_pkg::total_t      total;

	modport source (output valid, output coord_x, output coord_y, output last,
		output error, output total, input ready);
	modport sink   (input valid, input coord_x, input coord_y, input last,
		input error, input total, output ready);
endinterface

// ===== src/grid_band_coordinate_generator.sv =====
// Top level: grid walk coordinate generator with geometry pipe and output skid.
//
// Usage:
//  - req channel: one word per coordinate; restart=1 jumps back to the first
//    coordinate of the walk, restart=0 advances to the next one.
//  - rsp channel: one word per request with coord_x/coord_y (1-based), last on
//    the final coordinate before the walk wraps, error for an unknown mode
//    (coordinates 0), and total, the length of the whole walk.
//  - cfg port: cfg_we/cfg_index/cfg_data write one register per cycle; write
//    only while no word is in flight.
// Timing:
//  - results are registered (result register, skid on a stall); one word per
//    cycle is sustained while the receiver keeps up and no write settles.
//  - region bounds, extents, areas and totals run in a four-stage geometry
//    pipe off the config registers; req.ready drops after reset and after
//    every config write while that pipe refills.
//  - a result register plus one skid register sit on the rsp side: a stalled
//    receiver still lets one more request in, after that req.ready drops.
// Reset: config to its defaults, walk position to the first coordinate,
//    result and skid registers empty.
module grid_band_coordinate_generator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [2:0]                   cfg_index,
	input  logic [gbcg_pkg::CFG_W-1:0]   cfg_data,
	gbcg_req_if.sink                     req,
	gbcg_rsp_if.source                   rsp
);

	// ---------------- config registers ----------------
	logic [2:0]  walk_mode_q;
	logic [12:0] grid_cols_q;
	logic [12:0] grid_rows_q;
	logic [7:0]  border_q;
	logic [4:0]  stencil_q;
	logic        free_surf_q;
	logic [12:0] band_row_q;
	logic [2:0]  settle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_mode_q <= gbcg_pkg::MODE_FRAME;
			grid_cols_q <= 13'd256;
			grid_rows_q <= 13'd256;
			border_q    <= 8'd10;
			stencil_q   <= 5'd8;
			free_surf_q <= 1'b0;
			band_row_q  <= 13'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				gbcg_pkg::REG_WALK_MODE: walk_mode_q <= cfg_data[2:0];
				gbcg_pkg::REG_GRID_COLS: grid_cols_q <= cfg_data[12:0];
				gbcg_pkg::REG_GRID_ROWS: grid_rows_q <= cfg_data[12:0];
				gbcg_pkg::REG_BORDER:    border_q    <= cfg_data[7:0];
				gbcg_pkg::REG_STENCIL:   stencil_q   <= cfg_data[4:0];
				gbcg_pkg::REG_FREE_SURF: free_surf_q <= cfg_data[0];
				gbcg_pkg::REG_BAND_ROW:  band_row_q  <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= gbcg_pkg::SETTLE_CYCLES;
		end else if (cfg_we) begin
			settle_q <= gbcg_pkg::SETTLE_CYCLES;
		end else if (settle_q != 3'd0) begin
			settle_q <= settle_q - 3'd1;
		end
	end

	// ---------------- geometry stage 1: region bounds ----------------
	gbcg_pkg::gpos_t xlo_c [gbcg_pkg::NREG];
	gbcg_pkg::gpos_t xhi_c [gbcg_pkg::NREG];
	gbcg_pkg::gpos_t ylo_c [gbcg_pkg::NREG];
	gbcg_pkg::gpos_t yhi_c [gbcg_pkg::NREG];
	logic            mode_ok_c;
	logic            y_inner_c;

	gbcg_pkg::gpos_t xlo_s1 [gbcg_pkg::NREG];
	gbcg_pkg::gpos_t xhi_s1 [gbcg_pkg::NREG];
	gbcg_pkg::gpos_t ylo_s1 [gbcg_pkg::NREG];
	gbcg_pkg::gpos_t yhi_s1 [gbcg_pkg::NREG];
	logic            mode_ok_s1;
	logic            y_inner_s1;

	always_comb begin
		gbcg_pkg::dim_t  nx, ny, brow;
		gbcg_pkg::gpos_t w, fw, nxs, nys, y1, y2, y3, y4, x1, x2, x3, x4, b;
		nx   = (grid_cols_q > 13'(gbcg_pkg::MAX_DIM)) ? 13'(gbcg_pkg::MAX_DIM) : grid_cols_q;
		ny   = (grid_rows_q > 13'(gbcg_pkg::MAX_DIM)) ? 13'(gbcg_pkg::MAX_DIM) : grid_rows_q;
		brow = (band_row_q  > 13'(gbcg_pkg::MAX_DIM)) ? 13'(gbcg_pkg::MAX_DIM) : band_row_q;
		w    = gbcg_pkg::gpos_t'({11'd0, stencil_q[4:1]});
		fw   = gbcg_pkg::gpos_t'({7'd0, border_q});
		nxs  = gbcg_pkg::gpos_t'({2'd0, nx});
		nys  = gbcg_pkg::gpos_t'({2'd0, ny});
		b    = gbcg_pkg::gpos_t'({2'd0, brow});
		y1   = free_surf_q ? 15'sd2 : fw + 15'sd1;
		y2   = y1 + w - 15'sd1;
		y4   = nys - fw;
		y3   = y4 - w + 15'sd1;
		x1   = fw + 15'sd1;
		x2   = x1 + w - 15'sd1;
		x4   = nxs - fw;
		x3   = x4 - w + 15'sd1;
		for (int k = 0; k < gbcg_pkg::NREG; k++) begin
			xlo_c[k] = 15'sd1;
			xhi_c[k] = 15'sd0;
			ylo_c[k] = 15'sd1;
			yhi_c[k] = 15'sd0;
		end
		mode_ok_c = 1'b1;
		y_inner_c = 1'b1;
		case (walk_mode_q)
			gbcg_pkg::MODE_FRAME: begin
				xlo_c[0] = x1; xhi_c[0] = x4; ylo_c[0] = y1;          yhi_c[0] = y2;
				xlo_c[1] = x1; xhi_c[1] = x4; ylo_c[1] = y3;          yhi_c[1] = y4;
				xlo_c[2] = x1; xhi_c[2] = x2; ylo_c[2] = y2 + 15'sd1; yhi_c[2] = y3 - 15'sd1;
				xlo_c[3] = x3; xhi_c[3] = x4; ylo_c[3] = y2 + 15'sd1; yhi_c[3] = y3 - 15'sd1;
			end
			gbcg_pkg::MODE_BAND: begin
				xlo_c[0] = 15'sd1; xhi_c[0] = nxs; ylo_c[0] = b; yhi_c[0] = b + w - 15'sd1;
				y_inner_c = 1'b0;
			end
			gbcg_pkg::MODE_GRID: begin
				xlo_c[0] = 15'sd1; xhi_c[0] = nxs; ylo_c[0] = 15'sd1; yhi_c[0] = nys;
			end
			default: mode_ok_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		xlo_s1     <= xlo_c;
		xhi_s1     <= xhi_c;
		ylo_s1     <= ylo_c;
		yhi_s1     <= yhi_c;
		mode_ok_s1 <= mode_ok_c;
		y_inner_s1 <= y_inner_c;
	end

	// ---------------- geometry stage 2: extents ----------------
	gbcg_pkg::dim_t xe_s2 [gbcg_pkg::NREG];
	gbcg_pkg::dim_t ye_s2 [gbcg_pkg::NREG];

	always_ff @(posedge clk) begin
		for (int k = 0; k < gbcg_pkg::NREG; k++) begin
			xe_s2[k] <= (xhi_s1[k] >= xlo_s1[k]) ?
				13'(xhi_s1[k] - xlo_s1[k] + 15'sd1) : 13'd0;
			ye_s2[k] <= (yhi_s1[k] >= ylo_s1[k]) ?
				13'(yhi_s1[k] - ylo_s1[k] + 15'sd1) : 13'd0;
		end
	end

	// ---------------- geometry stage 3: areas ----------------
	gbcg_pkg::total_t       area_s3 [gbcg_pkg::NREG];
	logic [gbcg_pkg::NREG-1:0] ne_s3;

	always_ff @(posedge clk) begin
		for (int k = 0; k < gbcg_pkg::NREG; k++) begin
			area_s3[k] <= {12'd0, xe_s2[k]} * {12'd0, ye_s2[k]};
			ne_s3[k]   <= (xe_s2[k] != 13'd0) && (ye_s2[k] != 13'd0);
		end
	end

	// ---------------- geometry stage 4: total and region order ----------------
	gbcg_pkg::total_t total_s4;
	logic [1:0]       first_s4;
	logic             any_s4;
	logic [1:0]       next_s4 [gbcg_pkg::NREG];
	logic [gbcg_pkg::NREG-1:0] wrap_s4;

	always_ff @(posedge clk) begin
		logic [26:0] sum;
		logic [1:0]  first;
		logic [1:0]  nxt;
		logic        wrp;
		sum   = 27'({2'd0, area_s3[0]}) + 27'({2'd0, area_s3[1]})
		      + 27'({2'd0, area_s3[2]}) + 27'({2'd0, area_s3[3]});
		first = 2'd0;
		for (int j = gbcg_pkg::NREG - 1; j >= 0; j--) begin
			if (ne_s3[j]) first = 2'(j);
		end
		total_s4 <= (sum > 27'({2'd0, {gbcg_pkg::TOTAL_W{1'b1}}})) ?
			{gbcg_pkg::TOTAL_W{1'b1}} : sum[gbcg_pkg::TOTAL_W-1:0];
		first_s4 <= first;
		any_s4   <= |ne_s3;
		for (int k = 0; k < gbcg_pkg::NREG; k++) begin
			nxt = first;
			wrp = 1'b1;
			for (int j = gbcg_pkg::NREG - 1; j >= 0; j--) begin
				if (j > k && ne_s3[j]) begin
					nxt = 2'(j);
					wrp = 1'b0;
				end
			end
			next_s4[k] <= nxt;
			wrap_s4[k] <= wrp;
		end
	end

	// ---------------- walk state and step ----------------
	logic [1:0]      reg_q;
	gbcg_pkg::dim_t  col_q, row_q;
	logic [1:0]      reg_d;
	gbcg_pkg::dim_t  col_d, row_d;
	gbcg_pkg::rsp_t  res_c;
	logic            accept;

	always_comb begin
		logic [gbcg_pkg::NREG-1:0] pos_ok;
		logic           jump;
		logic [1:0]     cur;
		gbcg_pkg::dim_t ccol, crow, ie, oe, inner, outer, inner_n, outer_n;
		logic [13:0]    inner_inc, outer_inc;
		logic           inner_wrap, outer_wrap;
		logic [14:0]    xs, ys;

		for (int k = 0; k < gbcg_pkg::NREG; k++) begin
			pos_ok[k] = ne_s3[k] && (col_q < xe_s2[k]) && (row_q < ye_s2[k]);
		end
		jump = req.restart || !pos_ok[reg_q];
		cur  = jump ? first_s4 : reg_q;
		ccol = jump ? 13'd0 : col_q;
		crow = jump ? 13'd0 : row_q;

		xs = xlo_s1[cur] + {2'd0, ccol};
		ys = ylo_s1[cur] + {2'd0, crow};

		// inner counter is the row in frame and grid walks, the column in band walks
		ie    = y_inner_s1 ? ye_s2[cur] : xe_s2[cur];
		oe    = y_inner_s1 ? xe_s2[cur] : ye_s2[cur];
		inner = y_inner_s1 ? crow : ccol;
		outer = y_inner_s1 ? ccol : crow;
		inner_inc  = {1'b0, inner} + 14'd1;
		outer_inc  = {1'b0, outer} + 14'd1;
		inner_wrap = inner_inc >= {1'b0, ie};
		outer_wrap = outer_inc >= {1'b0, oe};
		inner_n = inner_wrap ? 13'd0 : inner_inc[12:0];
		outer_n = inner_wrap ? (outer_wrap ? 13'd0 : outer_inc[12:0]) : outer;

		reg_d = (inner_wrap && outer_wrap) ? next_s4[cur] : cur;
		col_d = y_inner_s1 ? outer_n : inner_n;
		row_d = y_inner_s1 ? inner_n : outer_n;

		res_c.coord_x = xs[12:0];
		res_c.coord_y = ys[12:0];
		res_c.last    = inner_wrap && outer_wrap && wrap_s4[cur];
		res_c.error   = 1'b0;
		res_c.total   = total_s4;

		if (!mode_ok_s1) begin
			// unknown mode: error word, walk back to start
			reg_d = 2'd0; col_d = 13'd0; row_d = 13'd0;
			res_c = '0;
			res_c.error = 1'b1;
		end else if (!any_s4) begin
			// nothing to walk: a lone last word
			reg_d = 2'd0; col_d = 13'd0; row_d = 13'd0;
			res_c = '0;
			res_c.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_q <= 2'd0;
			col_q <= 13'd0;
			row_q <= 13'd0;
		end else if (accept) begin
			reg_q <= reg_d;
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	// ---------------- result register and skid ----------------
	gbcg_pkg::rsp_t out_q, skid_q;
	logic           out_v_q, skid_v_q;
	logic           take;
	logic           out_free;

	assign req.ready = !skid_v_q && (settle_q == 3'd0);
	assign accept    = req.valid && req.ready;
	assign take      = rsp.valid && rsp.ready;
	assign out_free  = !out_v_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			// skid full implies no accept this cycle
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q  <= accept;
			end
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q) out_q <= skid_q;
			else if (accept) out_q <= res_c;
		end else if (accept) begin
			skid_q <= res_c;
		end
	end

	assign rsp.valid   = out_v_q;
	assign rsp.coord_x = out_q.coord_x;
	assign rsp.coord_y = out_q.coord_y;
	assign rsp.last    = out_q.last;
	assign rsp.error   = out_q.error;
	assign rsp.total   = out_q.total;

	// ---------------- checks ----------------
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid word held with empty result register");

	a_no_accept_settling: assert property (@(posedge clk) disable iff (!arst_n)
		(settle_q != 3'd0) |-> !accept)
		else $error("request taken while geometry pipe refills");

	a_cfg_blocks_next: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !req.ready)
		else $error("ready high right after config write");

	a_error_word_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.error) |-> (rsp.coord_x == '0 && rsp.coord_y == '0
			&& !rsp.last && rsp.total == '0))
		else $error("error word carries coordinate data");

endmodule
